// ===== hw/rtl/lpsht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lpsht_pkg;

    localparam int LEN_W = 6;

    localparam logic [2:0] ADDR_SLOTS = 3'd0;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;

    localparam logic [8:0] SLOTS_RESET = 9'd256;
    localparam logic [8:0] COUNT_MAX   = 9'h1FF;

    // one queued key operation
    typedef struct packed {
        logic [31:0]      hash;
        logic [1:0]       req;
        logic [15:0]      loc;
        logic [LEN_W-1:0] len;
        logic             ovf;
    } cmd_t;

    typedef struct packed {
        logic             occ;
        logic [LEN_W-1:0] len;
        logic [15:0]      loc;
    } slot_word_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

    typedef enum logic [3:0] {
        B_CLEAR, B_IDLE, B_FIN1, B_FIN2, B_DIV, B_PRB_RD, B_PRB_CHK,
        B_CMP_RD, B_CMP_CHK, B_CPY_RD, B_CPY_WR, B_RESP
    } back_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lpsht_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// two-entry command queue, each entry with its own key bank
module lpsht_cmd_fifo #(
    parameter int JIW = 5
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire lpsht_pkg::cmd_t push_cmd,
    input  wire logic            key_we,
    input  wire logic [JIW-1:0]  key_widx,
    input  wire logic [7:0]      key_wdata,
    input  wire logic            pop,
    output lpsht_pkg::cmd_t      head_cmd,
    output logic                 empty,
    output logic                 full,
    input  wire logic [JIW-1:0]  key_ridx,
    output logic [7:0]           key_rdata
);
    lpsht_pkg::cmd_t cmd_mem [2];
    logic [7:0] key_mem [2 << JIW];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);
    assign head_cmd = cmd_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop) count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) cmd_mem[wr_ptr_reg] <= push_cmd;
        if (key_we) key_mem[{wr_ptr_reg, key_widx}] <= key_wdata;
        key_rdata <= key_mem[{rd_ptr_reg, key_ridx}];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/lpsht_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// per-byte hashing and key capture
module lpsht_front #(
    parameter int MAX_KEY_BYTES = 32,
    parameter int JIW = 5
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          key_byte,
    input  wire logic [15:0]         loc_value,
    input  wire logic [1:0]          req_type,
    input  wire logic                key_last,
    input  wire logic                fifo_full,
    input  wire lpsht_pkg::back_stat_t stat,
    output logic                     push,
    output lpsht_pkg::cmd_t          push_cmd,
    output logic                     key_we,
    output logic [JIW-1:0]           key_widx,
    output logic [7:0]               key_wdata
);
    localparam int LW = lpsht_pkg::LEN_W;

    logic [31:0]   hash_reg;
    logic [LW-1:0] len_reg;
    logic          ovf_reg;
    logic [31:0]   h1, h2, h3;
    logic          room, take;
    logic [LW-1:0] len_n;
    logic          ovf_n;

    assign s_tready = !fifo_full && !stat.clearing;
    assign take     = s_tvalid && s_tready;
    assign room     = (len_reg < LW'(MAX_KEY_BYTES));

    always_comb begin
        h1 = hash_reg + {{24{key_byte[7]}}, key_byte};
        h2 = h1 + (h1 << 10);
        h3 = h2 ^ (h2 >> 6);
    end

    assign len_n = room ? len_reg + LW'(1) : len_reg;
    assign ovf_n = ovf_reg || !room;

    assign key_we    = take && room;
    assign key_widx  = len_reg[JIW-1:0];
    assign key_wdata = key_byte;

    assign push = take && key_last && (req_type != lpsht_pkg::REQ_UNUSED);
    always_comb begin
        push_cmd.hash = h3;
        push_cmd.req  = req_type;
        push_cmd.loc  = loc_value;
        push_cmd.len  = len_n;
        push_cmd.ovf  = ovf_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else if (take) begin
            if (key_last) begin
                hash_reg <= '0;
                len_reg  <= '0;
                ovf_reg  <= 1'b0;
            end else begin
                hash_reg <= h3;
                len_reg  <= len_n;
                ovf_reg  <= ovf_n;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/lpsht_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// hash finish, slot reduction, probe walk and table memories
module lpsht_back #(
    parameter int TABLE_SLOTS = 256,
    parameter int JIW = 5
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [8:0]      slots_cfg,
    input  wire lpsht_pkg::cmd_t cmd,
    input  wire logic            cmd_valid,
    output logic                 pop,
    output logic [JIW-1:0]       key_ridx,
    input  wire logic [7:0]      key_rdata,
    output lpsht_pkg::back_stat_t stat,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [2:0]           m_status,
    output logic [15:0]          m_loc,
    output logic [7:0]           m_slot,
    output logic [31:0]          m_hash
);
    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int SW = $clog2(TABLE_SLOTS + 1);
    localparam int LW = lpsht_pkg::LEN_W;

    lpsht_pkg::back_state_t state_reg, state_next;

    lpsht_pkg::slot_word_t slot_mem [TABLE_SLOTS];
    logic [7:0]            key_mem [TABLE_SLOTS << JIW];
    lpsht_pkg::slot_word_t slot_rd;
    logic [7:0]            key_rd;

    logic [AW-1:0] clr_reg, s_reg;
    logic [SW-1:0] i_reg, n_eff;
    logic [LW-1:0] j_reg;
    logic [31:0]   h_reg, dv_reg, t_fin;
    logic [SW:0]   rem_reg, rem_sh, rem_step;
    logic [4:0]    cnt_reg;
    logic [8:0]    entries_reg;
    logic [2:0]    res_status_reg;
    logic [15:0]   res_loc_reg;
    logic [7:0]    res_slot_reg;

    logic                  slot_we, key_we, go_copy, go_cmp, adv, j_inc, copy_done;
    logic                  set_res, out_load, cnt_dec;
    lpsht_pkg::slot_word_t slot_wd;
    logic [2:0]            res_status_n;
    logic [15:0]           res_loc_n;
    logic [7:0]            res_slot_n;
    logic                  last_i, last_j, wrap_s;

    always_comb begin
        if (slots_cfg == 9'd0) n_eff = SW'(1);
        else if (32'(slots_cfg) > 32'(TABLE_SLOTS)) n_eff = SW'(TABLE_SLOTS);
        else n_eff = SW'(slots_cfg);
    end

    assign last_i = (32'(i_reg) + 32'd1 == 32'(n_eff));
    assign wrap_s = (32'(s_reg) + 32'd1 == 32'(n_eff));
    assign last_j = (j_reg + LW'(1) == cmd.len);
    assign key_ridx = j_reg[JIW-1:0];
    assign stat.clearing = (state_reg == lpsht_pkg::B_CLEAR);

    assign t_fin    = h_reg + (h_reg << 3);
    assign rem_sh   = {rem_reg[SW-1:0], dv_reg[31]};
    assign rem_step = (rem_sh >= {1'b0, n_eff}) ? rem_sh - {1'b0, n_eff} : rem_sh;

    // control strobes
    always_comb begin
        slot_we = 1'b0; slot_wd = '0; key_we = 1'b0;
        go_copy = 1'b0; go_cmp = 1'b0; adv = 1'b0; j_inc = 1'b0;
        copy_done = 1'b0; set_res = 1'b0; out_load = 1'b0; pop = 1'b0;
        cnt_dec = 1'b0;
        res_status_n = lpsht_pkg::ST_NOT_FOUND; res_loc_n = '0; res_slot_n = '0;
        case (state_reg)
            lpsht_pkg::B_CLEAR: begin
                slot_we = 1'b1;
            end
            lpsht_pkg::B_DIV: begin
                if (cnt_reg == 5'd31 && cmd.ovf) begin
                    set_res = 1'b1;
                    res_status_n = lpsht_pkg::ST_TOO_LONG;
                end
            end
            lpsht_pkg::B_PRB_CHK: begin
                if (cmd.req == lpsht_pkg::REQ_INSERT) begin
                    if (!slot_rd.occ) begin
                        slot_we = 1'b1;
                        slot_wd = '{occ: 1'b1, len: cmd.len, loc: cmd.loc};
                        go_copy = 1'b1;
                        set_res = 1'b1;
                        res_status_n = lpsht_pkg::ST_INSERTED;
                        res_slot_n = 8'(s_reg);
                    end else begin
                        adv = 1'b1;
                    end
                end else if (i_reg == '0 && !slot_rd.occ) begin
                    set_res = 1'b1;
                end else if (slot_rd.occ && slot_rd.len == cmd.len) begin
                    go_cmp = 1'b1;
                end else begin
                    adv = 1'b1;
                end
            end
            lpsht_pkg::B_CMP_CHK: begin
                if (key_rd == key_rdata) begin
                    if (last_j) begin
                        set_res = 1'b1;
                        res_status_n = lpsht_pkg::ST_FOUND;
                        res_loc_n = slot_rd.loc;
                        res_slot_n = 8'(s_reg);
                        if (cmd.req == lpsht_pkg::REQ_REMOVE) begin
                            slot_we = 1'b1;
                            slot_wd = '{occ: 1'b0, len: slot_rd.len, loc: slot_rd.loc};
                            cnt_dec = 1'b1;
                        end
                    end else begin
                        j_inc = 1'b1;
                    end
                end else begin
                    adv = 1'b1;
                end
            end
            lpsht_pkg::B_CPY_WR: begin
                key_we = 1'b1;
                copy_done = last_j;
            end
            lpsht_pkg::B_RESP: begin
                out_load = !m_tvalid || m_tready;
                pop = out_load;
            end
            default: ;
        endcase
        // walk exhausted without a result
        if (adv && last_i) begin
            set_res = 1'b1;
            res_status_n = (cmd.req == lpsht_pkg::REQ_INSERT) ?
                           lpsht_pkg::ST_FULL : lpsht_pkg::ST_NOT_FOUND;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lpsht_pkg::B_CLEAR:
                if (clr_reg == AW'(TABLE_SLOTS - 1)) state_next = lpsht_pkg::B_IDLE;
            lpsht_pkg::B_IDLE:
                if (cmd_valid) state_next = lpsht_pkg::B_FIN1;
            lpsht_pkg::B_FIN1: state_next = lpsht_pkg::B_FIN2;
            lpsht_pkg::B_FIN2: state_next = lpsht_pkg::B_DIV;
            lpsht_pkg::B_DIV:
                if (cnt_reg == 5'd31)
                    state_next = cmd.ovf ? lpsht_pkg::B_RESP : lpsht_pkg::B_PRB_RD;
            lpsht_pkg::B_PRB_RD: state_next = lpsht_pkg::B_PRB_CHK;
            lpsht_pkg::B_PRB_CHK: begin
                if (go_copy) state_next = lpsht_pkg::B_CPY_RD;
                else if (go_cmp) state_next = lpsht_pkg::B_CMP_RD;
                else if (set_res) state_next = lpsht_pkg::B_RESP;
                else state_next = lpsht_pkg::B_PRB_RD;
            end
            lpsht_pkg::B_CMP_RD: state_next = lpsht_pkg::B_CMP_CHK;
            lpsht_pkg::B_CMP_CHK: begin
                if (set_res) state_next = lpsht_pkg::B_RESP;
                else if (j_inc) state_next = lpsht_pkg::B_CMP_RD;
                else state_next = lpsht_pkg::B_PRB_RD;
            end
            lpsht_pkg::B_CPY_RD: state_next = lpsht_pkg::B_CPY_WR;
            lpsht_pkg::B_CPY_WR:
                state_next = copy_done ? lpsht_pkg::B_RESP : lpsht_pkg::B_CPY_RD;
            lpsht_pkg::B_RESP:
                if (out_load) state_next = lpsht_pkg::B_IDLE;
            default: state_next = lpsht_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lpsht_pkg::B_CLEAR;
            clr_reg     <= '0;
            entries_reg <= '0;
            m_tvalid    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == lpsht_pkg::B_CLEAR) clr_reg <= clr_reg + AW'(1);
            if (go_copy && entries_reg < lpsht_pkg::COUNT_MAX)
                entries_reg <= entries_reg + 9'd1;
            else if (cnt_dec && entries_reg != 9'd0)
                entries_reg <= entries_reg - 9'd1;
            if (out_load) m_tvalid <= 1'b1;
            else if (m_tready) m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            lpsht_pkg::B_IDLE: h_reg <= cmd.hash;
            lpsht_pkg::B_FIN1: h_reg <= t_fin ^ (t_fin >> 11);
            lpsht_pkg::B_FIN2: begin
                h_reg   <= h_reg + (h_reg << 15);
                dv_reg  <= h_reg + (h_reg << 15);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            lpsht_pkg::B_DIV: begin
                rem_reg <= rem_step;
                dv_reg  <= dv_reg << 1;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    s_reg <= AW'(rem_step);
                    i_reg <= '0;
                end
            end
            default: ;
        endcase
        if (adv && !last_i) begin
            i_reg <= i_reg + SW'(1);
            s_reg <= wrap_s ? '0 : s_reg + AW'(1);
        end
        if (go_copy || go_cmp) j_reg <= '0;
        else if (j_inc || (key_we && !copy_done)) j_reg <= j_reg + LW'(1);
        if (set_res) begin
            res_status_reg <= res_status_n;
            res_loc_reg    <= res_loc_n;
            res_slot_reg   <= res_slot_n;
        end
        if (out_load) begin
            m_status <= res_status_reg;
            m_loc    <= res_loc_reg;
            m_slot   <= res_slot_reg;
            m_hash   <= h_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_we) slot_mem[stat.clearing ? clr_reg : s_reg] <= slot_wd;
        slot_rd <= slot_mem[s_reg];
        if (key_we) key_mem[{s_reg, j_reg[JIW-1:0]}] <= key_rdata;
        key_rd <= key_mem[{s_reg, j_reg[JIW-1:0]}];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/linear_probe_string_hash_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Moves
// s_       in         one key byte per transaction, tlast on the final byte
// m_       out        one result per key (none for request code 3)
// apb      in         slot count register at byte address 0
//
// Key bytes are taken one per cycle while the command queue has room and no clearing pass runs.
// Per key the back end loads the command, finishes the hash (FIN1, FIN2),
// reduces it bit-serially modulo the slot count, reads and checks each probed
// slot, reads and compares or copies each key byte, and hands over the result.
// After reset a clearing pass over all TABLE_SLOTS slots holds s_tready low.
// The queue holds two keys, the one in the back end included; a result
// waiting on m_tready sits in the output register while the next key runs.
module linear_probe_string_hash_table_top #(
    parameter int TABLE_SLOTS   = 256,
    parameter int MAX_KEY_BYTES = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // key_byte[7:0], loc_value[23:8]
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // loc_out[15:0], slot_index[23:16], key_hash[55:24]
    output logic [2:0]       m_tuser,   // status[2:0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int JIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    logic [8:0] slots_reg;
    logic       push, pop, key_we, fifo_empty, fifo_full;
    lpsht_pkg::cmd_t       push_cmd, head_cmd;
    lpsht_pkg::back_stat_t stat;
    logic [JIW-1:0] key_widx, key_ridx;
    logic [7:0]     key_wdata, key_rdata;
    logic [15:0]    m_loc;
    logic [7:0]     m_slot;
    logic [31:0]    m_hash;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {23'd0, slots_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg <= lpsht_pkg::SLOTS_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            slots_reg <= pwdata[8:0];
        end
    end

    lpsht_front #(.MAX_KEY_BYTES(MAX_KEY_BYTES), .JIW(JIW)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .key_byte(s_tdata[7:0]), .loc_value(s_tdata[23:8]),
        .req_type(s_tuser), .key_last(s_tlast),
        .fifo_full(fifo_full), .stat(stat),
        .push(push), .push_cmd(push_cmd),
        .key_we(key_we), .key_widx(key_widx), .key_wdata(key_wdata)
    );

    lpsht_cmd_fifo #(.JIW(JIW)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_cmd(push_cmd),
        .key_we(key_we), .key_widx(key_widx), .key_wdata(key_wdata),
        .pop(pop), .head_cmd(head_cmd), .empty(fifo_empty), .full(fifo_full),
        .key_ridx(key_ridx), .key_rdata(key_rdata)
    );

    lpsht_back #(.TABLE_SLOTS(TABLE_SLOTS), .JIW(JIW)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .slots_cfg(slots_reg), .cmd(head_cmd), .cmd_valid(!fifo_empty),
        .pop(pop), .key_ridx(key_ridx), .key_rdata(key_rdata), .stat(stat),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_status(m_tuser), .m_loc(m_loc), .m_slot(m_slot), .m_hash(m_hash)
    );

    assign m_tdata = {m_hash, m_slot, m_loc};
endmodule
`default_nettype wire

// ===== bench/lpsht_checker.sv =====
`timescale 1ns / 1ps
module lpsht_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending,
    output int          checked
);
    localparam int NSLOTS = 256;
    localparam int KEYMAX = 32;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] loc;
        logic [7:0]  slot;
        logic [31:0] hash;
    } table_result_t;

    table_result_t results_due[$];

    logic [8:0]  slots_reg;
    logic [31:0] run_hash;
    logic [7:0]  key_buf[KEYMAX];
    int          key_len;
    bit          key_ovf;
    bit          occ[NSLOTS];
    logic [7:0]  slot_key[NSLOTS][KEYMAX];
    int          slot_len[NSLOTS];
    logic [15:0] slot_loc[NSLOTS];

    assign pending = results_due.size();

    function automatic bit key_equal(int s);
        if (slot_len[s] != key_len) return 0;
        for (int j = 0; j < key_len; j++)
            if (slot_key[s][j] != key_buf[j]) return 0;
        return 1;
    endfunction

    task automatic take_byte(logic [1:0] req, logic [7:0] b, logic last, logic [15:0] loc);
        logic [31:0]   h;
        int            n, home, s;
        table_result_t r;
        h = run_hash + {{24{b[7]}}, b};
        h += h << 10;
        h ^= h >> 6;
        run_hash = h;
        if (key_len < KEYMAX) begin
            key_buf[key_len] = b;
            key_len++;
        end else begin
            key_ovf = 1;
        end
        if (!last) return;
        h += h << 3;
        h ^= h >> 11;
        h += h << 15;
        if (req != lpsht_pkg::REQ_UNUSED) begin
            n = (slots_reg == 0) ? 1 : (slots_reg > NSLOTS) ? NSLOTS : slots_reg;
            home = h % n;
            r.status = lpsht_pkg::ST_NOT_FOUND;
            r.loc = '0;
            r.slot = '0;
            r.hash = h;
            if (key_ovf) begin
                r.status = lpsht_pkg::ST_TOO_LONG;
            end else if (req == lpsht_pkg::REQ_INSERT) begin
                r.status = lpsht_pkg::ST_FULL;
                for (int i = 0; i < n; i++) begin
                    s = (home + i) % n;
                    if (!occ[s]) begin
                        occ[s] = 1;
                        for (int j = 0; j < key_len; j++) slot_key[s][j] = key_buf[j];
                        slot_len[s] = key_len;
                        slot_loc[s] = loc;
                        r.status = lpsht_pkg::ST_INSERTED;
                        r.slot = s[7:0];
                        break;
                    end
                end
            end else if (occ[home]) begin
                for (int i = 0; i < n; i++) begin
                    s = (home + i) % n;
                    if (occ[s] && key_equal(s)) begin
                        r.status = lpsht_pkg::ST_FOUND;
                        r.loc = slot_loc[s];
                        r.slot = s[7:0];
                        if (req == lpsht_pkg::REQ_REMOVE) occ[s] = 0;
                        break;
                    end
                end
            end
            results_due.push_back(r);
        end
        key_len = 0;
        run_hash = '0;
        key_ovf = 0;
    endtask

    always @(posedge aclk) begin
        table_result_t e;
        if (!aresetn) begin
            slots_reg <= lpsht_pkg::SLOTS_RESET;
            run_hash = '0;
            key_len = 0;
            key_ovf = 0;
            foreach (occ[i]) occ[i] = 0;
            results_due.delete();
            errors <= 0;
            checked <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == lpsht_pkg::ADDR_SLOTS)
                slots_reg <= pwdata[8:0];
            if (s_tvalid && s_tready)
                take_byte(s_tuser, s_tdata[7:0], s_tlast, s_tdata[23:8]);
            if (m_tvalid && m_tready) begin
                checked <= checked + 1;
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result status=%0d tdata=%h", $time, m_tuser,
                             m_tdata);
                    errors <= errors + 1;
                end else begin
                    e = results_due.pop_front();
                    if (e.status !== m_tuser || e.loc !== m_tdata[15:0]
                            || e.slot !== m_tdata[23:16] || e.hash !== m_tdata[55:24]) begin
                        $display("%0t: mismatch exp status=%0d loc=%h slot=%0d hash=%h",
                                 $time, e.status, e.loc, e.slot, e.hash);
                        $display("%0t:          act status=%0d loc=%h slot=%0d hash=%h",
                                 $time, m_tuser, m_tdata[15:0], m_tdata[23:16],
                                 m_tdata[55:24]);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== bench/tb_linear_probe_string_hash_table_top.sv =====
`timescale 1ns / 1ps
module tb_linear_probe_string_hash_table_top;

    localparam int POOL = 12;
    localparam int SETTLE = 20000;
    localparam int BUDGET = 190;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int  errors, pending, checked;
    int  cycles = 0;
    int  keys_sent = 0;
    bit  no_idle = 0;

    logic [7:0] pool_key[POOL][40];
    int         pool_len[POOL];

    linear_probe_string_hash_table_top dut (.*);

    lpsht_checker chk (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        m_tready <= no_idle || ($urandom_range(99) >= 13);
        if (cycles > 20_000_000) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic reg_write(logic [31:0] v);
        @(posedge aclk);
        psel <= 1; pwrite <= 1; paddr <= lpsht_pkg::ADDR_SLOTS; pwdata <= v; penable <= 0;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic put_byte(logic [1:0] req, logic [7:0] b, logic last, logic [15:0] loc);
        if (!no_idle && $urandom_range(99) < 13) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {loc, b};
        s_tuser <= req;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // key from a list of bytes; earlier bytes carry a random request code
    task automatic send_key(logic [1:0] req, int len, logic [7:0] k[40], logic [15:0] loc);
        for (int i = 0; i < len; i++)
            put_byte(i == len - 1 ? req : 2'($urandom), k[i], i == len - 1,
                     i == len - 1 ? loc : 16'($urandom));
        keys_sent++;
    endtask

    task automatic send_short(logic [1:0] req, logic [7:0] b, logic [15:0] loc);
        logic [7:0] k[40];
        k[0] = b;
        send_key(req, 1, k, loc);
    endtask

    // lets the table drain before a register write
    task automatic drain;
        s_tvalid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic random_phase(int budget);
        int         spent, p, len;
        logic [1:0] req;
        logic [7:0] k[40];
        for (int i = 0; i < POOL; i++) begin
            pool_len[i] = $urandom_range(1, 6);
            if (i == 0) pool_len[i] = 32;
            for (int j = 0; j < 40; j++) pool_key[i][j] = 8'($urandom);
        end
        spent = 0;
        while (spent < budget) begin
            p = $urandom_range(99);
            req = p < 40 ? lpsht_pkg::REQ_INSERT : p < 70 ? lpsht_pkg::REQ_LOOKUP :
                  p < 95 ? lpsht_pkg::REQ_REMOVE : lpsht_pkg::REQ_UNUSED;
            if ($urandom_range(99) < 85) begin
                p = $urandom_range(POOL - 1);
                len = pool_len[p];
                k = pool_key[p];
            end else begin
                len = $urandom_range(99) < 15 ? $urandom_range(30, 36) : $urandom_range(1, 8);
                for (int j = 0; j < 40; j++) k[j] = 8'($urandom);
            end
            send_key(req, len, k, 16'($urandom));
            spent += len;
        end
    endtask

    initial begin
        int settings[8] = '{1, 0, 300, 7, 16, 511, 3, 64};
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        // sign extension of the byte, empty table, remove and re-lookup, duplicates
        send_short(lpsht_pkg::REQ_LOOKUP, 8'h00, 16'h0);
        send_short(lpsht_pkg::REQ_INSERT, 8'h00, 16'hFFFF);
        send_short(lpsht_pkg::REQ_INSERT, 8'hFF, 16'h0000);
        send_short(lpsht_pkg::REQ_INSERT, 8'h80, 16'h1234);
        send_short(lpsht_pkg::REQ_INSERT, 8'h7F, 16'hA5A5);
        send_short(lpsht_pkg::REQ_INSERT, 8'h7F, 16'h5A5A);
        send_short(lpsht_pkg::REQ_LOOKUP, 8'h00, 16'h0);
        send_short(lpsht_pkg::REQ_LOOKUP, 8'hFF, 16'h0);
        send_short(lpsht_pkg::REQ_LOOKUP, 8'h80, 16'h0);
        send_short(lpsht_pkg::REQ_REMOVE, 8'h7F, 16'h0);
        send_short(lpsht_pkg::REQ_LOOKUP, 8'h7F, 16'h0);
        send_short(lpsht_pkg::REQ_REMOVE, 8'h7F, 16'h0);
        send_short(lpsht_pkg::REQ_LOOKUP, 8'h7F, 16'h0);
        send_short(lpsht_pkg::REQ_UNUSED, 8'h55, 16'h0);
        send_short(lpsht_pkg::REQ_REMOVE, 8'h01, 16'h0);
        random_phase(BUDGET);
        drain;

        foreach (settings[i]) begin
            reg_write(settings[i]);
            no_idle = (settings[i] == 16);
            random_phase(BUDGET);
            drain;
        end
        no_idle = 0;

        $display("Sent %0d keys over %0d slot-count settings incl. 0, 1 and above range;",
                 keys_sent, 9);
        $display("%0d results checked against the predicted table contents.", checked);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== linear_probe_string_hash_table_top.f =====
hw/rtl/lpsht_pkg.sv
hw/rtl/lpsht_cmd_fifo.sv
hw/rtl/lpsht_front.sv
hw/rtl/lpsht_back.sv
hw/rtl/linear_probe_string_hash_table_top.sv
bench/lpsht_checker.sv
bench/tb_linear_probe_string_hash_table_top.sv
